// ===== hdl/ordered_sequence_store_unit_defines.svh =====
// assertion macros for the ordered sequence store
`ifndef ORDERED_SEQUENCE_STORE_UNIT_DEFINES_SVH
`define ORDERED_SEQUENCE_STORE_UNIT_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define OSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/osu_pkg.sv =====
// shared constants, codes and types of the ordered sequence store
`default_nettype none

package osu_pkg;

  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);

  typedef logic signed [VALUE_WIDTH-1:0] elem_t;

  typedef enum logic [3:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_INSERT_AT  = 4'd2,
    CMD_POP_FRONT  = 4'd3,
    CMD_POP_BACK   = 4'd4,
    CMD_REMOVE_AT  = 4'd5,
    CMD_SEARCH     = 4'd6,
    CMD_SORT       = 4'd7,
    CMD_REVERSE    = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_INS  = 3'd1,
    CELL_DEL  = 3'd2,
    CELL_SORT = 3'd3,
    CELL_ROT  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
    logic             phase;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/osu_cell.sv =====
// one storage cell of the element chain
`default_nettype none

module osu_cell (
  input  logic                      clk,
  input  osu_pkg::cell_ctl_t        ctl,
  input  logic [osu_pkg::CNT_W-1:0] idx,
  input  osu_pkg::elem_t            left_data,
  input  osu_pkg::elem_t            right_data,
  input  osu_pkg::elem_t            bcast,
  input  osu_pkg::elem_t            key,
  input  logic                      gt_left,
  output osu_pkg::elem_t            data,
  output logic                      gt_right,
  output logic                      hit
);
  import osu_pkg::*;

  logic [CNT_W-1:0] idx_inc;
  logic             lower;

  assign idx_inc  = idx + CNT_W'(1);
  assign lower    = (idx[0] == ctl.phase);
  assign gt_right = (data > right_data);
  assign hit      = (data == key) && (idx < ctl.cnt);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_INS: begin
        if (idx == ctl.pos) begin
          data <= bcast;
        end else if (idx > ctl.pos) begin
          data <= left_data;
        end
      end
      CELL_DEL: begin
        if (idx >= ctl.pos) begin
          data <= right_data;
        end
      end
      CELL_SORT: begin
        if (lower && (idx_inc < ctl.cnt) && gt_right) begin
          data <= right_data;
        end else if (!lower && (idx != '0) && (idx < ctl.cnt) && gt_left) begin
          data <= left_data;
        end
      end
      CELL_ROT: begin
        if (idx < ctl.pos) begin
          data <= right_data;
        end else if (idx == ctl.pos) begin
          data <= bcast;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/osu_ctrl.sv =====
// command decode, sort and reverse sequencer, count and result register
`default_nettype none

module osu_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [3:0]                   command,
  input  logic [5:0]                   position,
  input  logic [osu_pkg::CAPACITY-1:0] hits,
  output osu_pkg::cell_ctl_t           ctl,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic                         found,
  output logic [4:0]                   match_index,
  output logic [5:0]                   count
);
  import osu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SORT = 3'b010,
    S_REV  = 3'b100
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] step, step_next;
  logic             take;
  logic             res_load;
  status_t          res_status;
  logic             res_found;
  logic [IDX_W-1:0] first_hit;
  logic [6:0]       pos7, cnt7, ipos7;
  logic [CNT_W-1:0] last;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign take     = in_valid && !in_stall;
  assign pos7     = 7'(position);
  assign cnt7     = 7'(cnt);
  assign last     = cnt - CNT_W'(1);

  always_comb begin
    first_hit = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hits[i]) begin
        first_hit = IDX_W'(i);
      end
    end
  end

  always_comb begin
    ipos7 = pos7;
    if (command == CMD_PUSH_FRONT) begin
      ipos7 = '0;
    end else if (command == CMD_PUSH_BACK) begin
      ipos7 = cnt7;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    step_next  = step;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_found  = 1'b0;
    ctl.op     = CELL_HOLD;
    ctl.pos    = '0;
    ctl.cnt    = cnt;
    ctl.phase  = step[0];
    unique case (state)
      S_IDLE: begin
        if (take) begin
          res_load = 1'b1;
          unique case (command) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
              if (ipos7 > cnt7) begin
                res_status = ST_RANGE;
              end else if (cnt7 >= 7'(CAPACITY)) begin
                res_status = ST_FULL;
              end else begin
                ctl.op   = CELL_INS;
                ctl.pos  = CNT_W'(ipos7);
                cnt_next = cnt + CNT_W'(1);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (cnt == '0) begin
                res_status = ST_EMPTY;
              end else begin
                ctl.op   = CELL_DEL;
                ctl.pos  = (command == CMD_POP_FRONT) ? '0 : last;
                cnt_next = last;
              end
            end
            CMD_REMOVE_AT: begin
              if (pos7 >= cnt7) begin
                res_status = ST_RANGE;
              end else begin
                ctl.op   = CELL_DEL;
                ctl.pos  = CNT_W'(pos7);
                cnt_next = last;
              end
            end
            CMD_SEARCH: begin
              res_found = |hits;
            end
            CMD_SORT: begin
              if (cnt7 >= 7'd2) begin
                res_load   = 1'b0;
                step_next  = '0;
                state_next = S_SORT;
              end
            end
            CMD_REVERSE: begin
              if (cnt7 >= 7'd2) begin
                res_load   = 1'b0;
                step_next  = last;
                state_next = S_REV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SORT: begin
        ctl.op    = CELL_SORT;
        step_next = step + CNT_W'(1);
        if (step == last) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REV: begin
        ctl.op    = CELL_ROT;
        ctl.pos   = step;
        step_next = step - CNT_W'(1);
        if (step == CNT_W'(1)) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step <= step_next;
    if (res_load) begin
      status      <= res_status;
      found       <= res_found;
      match_index <= res_found ? 5'(first_hit) : 5'd0;
      count       <= 6'(cnt_next);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ordered_sequence_store_unit.sv =====
// top level of the ordered sequence store: element cell chain and controller
//
//   channel  dir  handshake            fields
//   in       in   in_valid/in_stall    command, position, value
//   out      out  out_valid/out_stall  status, found, match_index, count
//
// inserts, removes, search and unknown commands: result registered on the next edge
// sort runs odd-even exchange passes along the cell chain, one per cycle
// reverse runs prefix rotations through the chain, one per cycle
// reset clears the count, state and result valid; cell contents are not cleared
// a waiting result blocks new words only while out_stall is high
`default_nettype none

module ordered_sequence_store_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         command,
  input  logic [5:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic               found,
  output logic [4:0]         match_index,
  output logic [5:0]         count
);
  import osu_pkg::*;

  cell_ctl_t             ctl;
  elem_t                 data [CAPACITY];
  logic [CAPACITY-1:0]   gt;
  logic [CAPACITY-1:0]   hits;
  logic signed [63:0]    value_ext;
  elem_t                 key;
  elem_t                 bcast;

  assign value_ext = 64'(value);
  assign key       = value_ext[VALUE_WIDTH-1:0];
  assign bcast     = (ctl.op == CELL_ROT) ? data[0] : key;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    elem_t left_data;
    elem_t right_data;
    logic  gt_left;

    if (g == 0) begin : g_first
      assign left_data = data[0];
      assign gt_left   = 1'b0;
    end else begin : g_mid
      assign left_data = data[g-1];
      assign gt_left   = gt[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_data = data[g];
    end else begin : g_inner
      assign right_data = data[g+1];
    end

    osu_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (CNT_W'(g)),
      .left_data  (left_data),
      .right_data (right_data),
      .bcast      (bcast),
      .key        (key),
      .gt_left    (gt_left),
      .data       (data[g]),
      .gt_right   (gt[g]),
      .hit        (hits[g])
    );
  end

  osu_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .position    (position),
    .hits        (hits),
    .ctl         (ctl),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found       (found),
    .match_index (match_index),
    .count       (count)
  );

endmodule

`default_nettype wire

// ===== hdl/osu_checker.sv =====
// port-level checks of the ordered sequence store and their bind
`default_nettype none

`include "ordered_sequence_store_unit_defines.svh"

module osu_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         status,
  input logic               found,
  input logic [4:0]         match_index,
  input logic [5:0]         count
);
  import osu_pkg::*;

  logic out_take;

  assign out_take = out_valid && !out_stall;

  `OSU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(count) && $stable(status), "stalled result changed")
  `OSU_ASSERT_NOW(a_full_count, out_take && (status == ST_FULL), count == 6'(CAPACITY), "full status with count below capacity")
  `OSU_ASSERT_NOW(a_empty_count, out_take && (status == ST_EMPTY), count == 6'd0, "empty status with nonzero count")
  `OSU_ASSERT_NOW(a_found_ok, out_take && found, (status == ST_OK) && (count != 6'd0), "search hit without ok status or elements")
  `OSU_ASSERT_NOW(a_miss_index, out_take && !found, match_index == 5'd0, "match index set without a hit")

endmodule

bind ordered_sequence_store_unit osu_checker u_osu_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the ordered sequence store unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import osu_pkg::*;

  localparam int NUM_RANDOM   = 1025;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = CAPACITY + 16;
  localparam int MAX_PRINTS   = 40;

  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  localparam elem_t ELEM_MAX  = 32'sh7FFF_FFFF;
  localparam elem_t ELEM_MIN  = 32'sh8000_0000;
  localparam elem_t ELEM_NEG1 = -32'sd1;

  typedef struct {
    status_t    st;
    logic       hit;
    logic [4:0] where;
    logic [5:0] len;
  } seq_result_t;

  typedef struct {
    logic [3:0]  cmd;
    logic [5:0]  pos;
    elem_t       val;
    seq_result_t want;
  } step_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [3:0] command = '0;
  logic [5:0] position = '0;
  elem_t      value = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic       found;
  logic [4:0] match_index;
  logic [5:0] count;

  logic hold_req = 1'b0;
  int   tx_idle_pct = 28;
  int   rx_idle_pct = 49;
  int   words_sent = 0;
  int   err_count = 0;

  elem_t       seq_mem [CAPACITY];
  int          seq_len = 0;
  seq_result_t expected_q [$];
  step_row_t   plan_q [$];

  ordered_sequence_store_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found       (found),
    .match_index (match_index),
    .count       (count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    if (err_count < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic status_t seq_insert(int at, elem_t v);
    if (at > seq_len) return ST_RANGE;
    if (seq_len >= CAPACITY) return ST_FULL;
    for (int i = seq_len; i > at; i--) seq_mem[i] = seq_mem[i - 1];
    seq_mem[at] = v;
    seq_len++;
    return ST_OK;
  endfunction

  function automatic void seq_remove(int at);
    for (int i = at; i + 1 < seq_len; i++) seq_mem[i] = seq_mem[i + 1];
    seq_len--;
  endfunction

  function automatic seq_result_t seq_apply(logic [3:0] cmd, logic [5:0] pos, elem_t v);
    seq_result_t r;
    elem_t       t;
    int          lo;
    int          hi;
    r.st = ST_OK;
    r.hit = 1'b0;
    r.where = '0;
    case (cmd)
      CMD_PUSH_FRONT: r.st = seq_insert(0, v);
      CMD_PUSH_BACK:  r.st = seq_insert(seq_len, v);
      CMD_INSERT_AT:  r.st = seq_insert(int'(pos), v);
      CMD_POP_FRONT: begin
        if (seq_len == 0) r.st = ST_EMPTY;
        else seq_remove(0);
      end
      CMD_POP_BACK: begin
        if (seq_len == 0) r.st = ST_EMPTY;
        else seq_remove(seq_len - 1);
      end
      CMD_REMOVE_AT: begin
        if (int'(pos) >= seq_len) r.st = ST_RANGE;
        else seq_remove(int'(pos));
      end
      CMD_SEARCH: begin
        // scan from the back so the first match wins
        for (int i = seq_len - 1; i >= 0; i--) begin
          if (seq_mem[i] == v) begin
            r.hit = 1'b1;
            r.where = 5'(i);
          end
        end
      end
      CMD_SORT: begin
        for (int i = 0; i < seq_len; i++) begin
          for (int j = i + 1; j < seq_len; j++) begin
            if (seq_mem[j] < seq_mem[i]) begin
              t = seq_mem[i];
              seq_mem[i] = seq_mem[j];
              seq_mem[j] = t;
            end
          end
        end
      end
      CMD_REVERSE: begin
        lo = 0;
        hi = seq_len - 1;
        while (lo < hi) begin
          t = seq_mem[lo];
          seq_mem[lo] = seq_mem[hi];
          seq_mem[hi] = t;
          lo++;
          hi--;
        end
      end
      default: ;
    endcase
    r.len = 6'(seq_len);
    return r;
  endfunction

  function automatic void plan(logic [3:0] cmd, logic [5:0] pos, elem_t v, status_t st,
                               logic hit, logic [4:0] where, logic [5:0] len);
    step_row_t r;
    r.cmd = cmd;
    r.pos = pos;
    r.val = v;
    r.want.st = st;
    r.want.hit = hit;
    r.want.where = where;
    r.want.len = len;
    plan_q.push_back(r);
  endfunction

  task automatic send_word(logic [3:0] cmd, logic [5:0] pos, elem_t v, bit typed,
                           seq_result_t want);
    seq_result_t got;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    position <= pos;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = seq_apply(cmd, pos, v);
    expected_q.push_back(typed ? want : got);
    words_sent++;
  endtask

  initial begin : stimulus
    seq_result_t blank;
    logic [3:0]  cmd;
    logic [5:0]  pos;
    elem_t       v;
    int          fill_goal;
    int          roll;
    bit          grow;
    blank = '{st: ST_OK, hit: 1'b0, where: '0, len: '0};
    fill_goal = 0;

    plan(CMD_SEARCH,     0,  0,         ST_OK,    1'b0, 0, 0);
    plan(CMD_POP_FRONT,  0,  0,         ST_EMPTY, 1'b0, 0, 0);
    plan(CMD_POP_BACK,   63, ELEM_MAX,  ST_EMPTY, 1'b0, 0, 0);
    plan(CMD_REMOVE_AT,  0,  0,         ST_RANGE, 1'b0, 0, 0);
    plan(CMD_INSERT_AT,  1,  ELEM_MAX,  ST_RANGE, 1'b0, 0, 0);
    plan(CMD_SORT,       0,  0,         ST_OK,    1'b0, 0, 0);
    plan(CMD_REVERSE,    0,  0,         ST_OK,    1'b0, 0, 0);
    plan(CMD_PUSH_BACK,  0,  ELEM_MAX,  ST_OK,    1'b0, 0, 1);
    plan(CMD_REVERSE,    0,  0,         ST_OK,    1'b0, 0, 1);
    plan(CMD_SORT,       0,  0,         ST_OK,    1'b0, 0, 1);
    plan(CMD_PUSH_FRONT, 0,  ELEM_MIN,  ST_OK,    1'b0, 0, 2);
    plan(CMD_INSERT_AT,  1,  ELEM_NEG1, ST_OK,    1'b0, 0, 3);
    plan(CMD_SEARCH,     0,  ELEM_NEG1, ST_OK,    1'b1, 1, 3);
    plan(CMD_SEARCH,     0,  ELEM_MAX,  ST_OK,    1'b1, 2, 3);
    plan(CMD_SEARCH,     0,  0,         ST_OK,    1'b0, 0, 3);
    plan(CMD_REVERSE,    0,  0,         ST_OK,    1'b0, 0, 3);
    plan(CMD_SEARCH,     0,  ELEM_MIN,  ST_OK,    1'b1, 2, 3);
    plan(CMD_SORT,       0,  0,         ST_OK,    1'b0, 0, 3);
    plan(CMD_SEARCH,     0,  ELEM_MAX,  ST_OK,    1'b1, 2, 3);
    plan(CMD_UNUSED_HI,  63, ELEM_NEG1, ST_OK,    1'b0, 0, 3);
    plan(CMD_REMOVE_AT,  3,  0,         ST_RANGE, 1'b0, 0, 3);
    plan(CMD_INSERT_AT,  63, 0,         ST_RANGE, 1'b0, 0, 3);
    plan(CMD_INSERT_AT,  3,  5,         ST_OK,    1'b0, 0, 4);
    plan(CMD_REMOVE_AT,  1,  0,         ST_OK,    1'b0, 0, 3);
    plan(CMD_POP_FRONT,  0,  0,         ST_OK,    1'b0, 0, 2);
    plan(CMD_POP_BACK,   0,  0,         ST_OK,    1'b0, 0, 1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_q[k]) send_word(plan_q[k].cmd, plan_q[k].pos, plan_q[k].val, 1'b1,
                                  plan_q[k].want);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) begin
        tx_idle_pct = 49;
        rx_idle_pct <= 28;
      end
      if (n == 2 * NUM_RANDOM / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (n % 64 == 0) begin
        case ($urandom_range(4))
          0: fill_goal = 0;
          1, 2: fill_goal = CAPACITY;
          3: fill_goal = $urandom_range(2, 6);
          default: fill_goal = $urandom_range(CAPACITY);
        endcase
      end

      // drift the fill level toward the goal, with queries and noise mixed in
      roll = $urandom_range(99);
      grow = (seq_len < fill_goal) || (fill_goal == CAPACITY);
      if (roll < 55) begin
        if (grow) cmd = 4'($urandom_range(int'(CMD_PUSH_FRONT), int'(CMD_INSERT_AT)));
        else cmd = 4'($urandom_range(int'(CMD_POP_FRONT), int'(CMD_REMOVE_AT)));
      end else if (roll < 70) begin
        cmd = CMD_SEARCH;
      end else if (roll < 78) begin
        cmd = CMD_SORT;
      end else if (roll < 86) begin
        cmd = CMD_REVERSE;
      end else if (roll < 90) begin
        cmd = 4'($urandom_range(int'(CMD_UNUSED_LO), int'(CMD_UNUSED_HI)));
      end else begin
        cmd = 4'($urandom_range(int'(CMD_PUSH_FRONT), int'(CMD_REMOVE_AT)));
      end

      case ($urandom_range(9))
        0: pos = 6'($urandom_range(63));
        1: pos = 6'(seq_len);
        default: pos = (seq_len == 0) ? 6'd0 : 6'($urandom_range(seq_len - 1));
      endcase

      case ($urandom_range(7))
        0: v = ELEM_MAX;
        1: v = ELEM_MIN;
        2, 3: v = elem_t'(int'($urandom_range(8)) - 4);
        default: v = elem_t'($urandom);
      endcase
      if (cmd == CMD_SEARCH && seq_len != 0 && $urandom_range(2) != 0)
        v = seq_mem[$urandom_range(seq_len - 1)];

      send_word(cmd, pos, v, 1'b0, blank);
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= hold_req || ($urandom_range(99) < rx_idle_pct);
  end

  // long receiver hold-off so the store backs up into its input
  initial begin : hold_off
    for (int k = 0; k < 2; k++) begin
      wait (words_sent >= ((k == 0) ? 200 : 800));
      @(posedge clk);
      hold_req <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_req <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    seq_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("word with nothing expected: status=%0d count=%0d",
                                  status, count));
      end else begin
        want = expected_q.pop_front();
        if (status !== want.st)
          report_mismatch($sformatf("status %0d, want %s", status, want.st.name()));
        if (found !== want.hit)
          report_mismatch($sformatf("found %0b, want %0b", found, want.hit));
        if (match_index !== want.where)
          report_mismatch($sformatf("match_index %0d, want %0d", match_index, want.where));
        if (count !== want.len)
          report_mismatch($sformatf("count %0d, want %0d", count, want.len));
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
